@@ hw/rtl/rzs_pkg.sv @@
// Package for the bitmap rotate/zoom sampler: sizes, field widths, codes,
// controller state type and the command/status structs.
// No dependencies.
package rzs_pkg;

    localparam int MAX_SIDE  = 64;
    localparam int FRAC_BITS = 16;

    localparam int POS_W     = 6;
    localparam int CFG_DIM_W = 7;
    localparam int COEF_W    = 20;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 20;

    localparam int IDX_W   = $clog2(MAX_SIDE);
    localparam int DEPTH   = MAX_SIDE * MAX_SIDE;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int DIM_W   = $clog2(MAX_SIDE + 1);
    localparam int XT_W    = DIM_W + 1;
    localparam int PROD_W  = COEF_W + XT_W;
    localparam int SUM_W   = PROD_W + 1;
    localparam int FL_W    = SUM_W - FRAC_BITS;
    localparam int COORD_W = ((FL_W > DIM_W) ? FL_W : DIM_W) + 1;

    localparam logic [CFG_DIM_W-1:0] WIDTH_RESET  = CFG_DIM_W'(64);
    localparam logic [CFG_DIM_W-1:0] HEIGHT_RESET = CFG_DIM_W'(64);
    localparam logic [COEF_W-1:0]    COS_RESET    = COEF_W'(65536);
    localparam logic [COEF_W-1:0]    SIN_RESET    = COEF_W'(0);

    typedef enum logic {
        CMD_WRITE = 1'b0,
        CMD_QUERY = 1'b1
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH  = 2'd0,
        CFG_IMAGE_HEIGHT = 2'd1,
        CFG_COS_ZOOM     = 2'd2,
        CFG_SIN_ZOOM     = 2'd3
    } cfg_index_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_SUM,
        S_READ,
        S_DONE
    } state_t;

    typedef struct packed {
        logic accept;
        logic mul_en;
        logic sum_en;
        logic read_en;
        logic out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic is_query;
    } ctrl_status_t;

endpackage

@@ hw/rtl/rzs_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rzs_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ hw/rtl/rzs_ctrl.sv @@
// Controller state machine of the sampler: sequences a query through
// multiply, sum, read and output, and owns the request handshakes. Uses rzs_pkg.
module rzs_ctrl import rzs_pkg::*; (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    output logic         out_valid,
    input  logic         out_ready,
    input  ctrl_status_t status,
    output ctrl_cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   accept;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && status.is_query)
                begin
                    state_next = S_MUL;
                end
            end
            S_MUL:  state_next = S_SUM;
            S_SUM:  state_next = S_READ;
            S_READ: state_next = S_DONE;
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        cmd.accept = accept;
        case (state_reg)
            S_MUL:  cmd.mul_en = 1'b1;
            S_SUM:  cmd.sum_en = 1'b1;
            S_READ: cmd.read_en = 1'b1;
            S_DONE: cmd.out_load = !out_valid_reg || out_ready;
            default: ;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    a_query_starts: assert property (@(posedge clk) disable iff (!rst_n)
        accept && status.is_query |=> state_reg == S_MUL)
        else $error("query accept did not start the multiply step");

    a_read_then_done: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_READ |=> state_reg == S_DONE)
        else $error("read step not followed by done");

    a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> out_valid_reg)
        else $error("result load did not raise out_valid");

    a_done_waits: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DONE && out_valid_reg && !out_ready |=> state_reg == S_DONE)
        else $error("result overwritten while still pending");

endmodule

@@ hw/rtl/rzs_datapath.sv @@
// Datapath of the sampler: configuration registers, inverse mapping
// arithmetic, bitmap RAM and output register. Uses rzs_pkg and rzs_ram.
module rzs_datapath import rzs_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  cmd,
    input  logic [POS_W-1:0]      pos_x,
    input  logic [POS_W-1:0]      pos_y,
    input  logic                  pixel_in,
    input  ctrl_cmd_t             ctrl,
    output ctrl_status_t          status,
    output logic                  pixel_out,
    output logic                  source_hit
);

    logic [CFG_DIM_W-1:0] image_width_reg;
    logic [CFG_DIM_W-1:0] image_height_reg;
    logic [COEF_W-1:0]    cos_zoom_reg;
    logic [COEF_W-1:0]    sin_zoom_reg;

    logic [DIM_W-1:0] w_eff;
    logic [DIM_W-1:0] h_eff;
    logic [DIM_W-1:0] hw;
    logic [DIM_W-1:0] hh;
    logic             in_range;

    logic [POS_W-1:0] px_reg;
    logic [POS_W-1:0] py_reg;
    logic             range_reg;

    logic signed [XT_W-1:0]   xt;
    logic signed [XT_W-1:0]   yt;
    logic signed [PROD_W-1:0] p_cx_reg;
    logic signed [PROD_W-1:0] p_sy_reg;
    logic signed [PROD_W-1:0] p_sx_reg;
    logic signed [PROD_W-1:0] p_cy_reg;

    logic signed [SUM_W-1:0]   sum_x;
    logic signed [SUM_W-1:0]   sum_y;
    logic signed [COORD_W-1:0] xs;
    logic signed [COORD_W-1:0] ys;
    logic signed [COORD_W-1:0] w_ext;
    logic signed [COORD_W-1:0] h_ext;
    logic                      mapped_in;

    logic [IDX_W-1:0] xs_idx_reg;
    logic [IDX_W-1:0] ys_idx_reg;
    logic             hit_reg;

    logic              ram_we;
    logic [ADDR_W-1:0] waddr;
    logic [ADDR_W-1:0] raddr;
    logic              ram_rdata;

    logic pixel_out_reg;
    logic source_hit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= WIDTH_RESET;
            image_height_reg <= HEIGHT_RESET;
            cos_zoom_reg     <= COS_RESET;
            sin_zoom_reg     <= SIN_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_IMAGE_WIDTH:  image_width_reg  <= cfg_data[CFG_DIM_W-1:0];
                CFG_IMAGE_HEIGHT: image_height_reg <= cfg_data[CFG_DIM_W-1:0];
                CFG_COS_ZOOM:     cos_zoom_reg     <= cfg_data[COEF_W-1:0];
                CFG_SIN_ZOOM:     sin_zoom_reg     <= cfg_data[COEF_W-1:0];
                default: ;
            endcase
        end
    end

    assign w_eff = (32'(image_width_reg) > MAX_SIDE) ? DIM_W'(MAX_SIDE)
                                                     : DIM_W'(image_width_reg);
    assign h_eff = (32'(image_height_reg) > MAX_SIDE) ? DIM_W'(MAX_SIDE)
                                                      : DIM_W'(image_height_reg);
    assign hw = w_eff >> 1;
    assign hh = h_eff >> 1;

    assign in_range = (DIM_W'(pos_x) < w_eff) && (DIM_W'(pos_y) < h_eff)
                      && (32'(pos_x) < MAX_SIDE) && (32'(pos_y) < MAX_SIDE);
    assign status.is_query = (cmd == CMD_QUERY);

    assign ram_we = ctrl.accept && (cmd == CMD_WRITE) && in_range;
    assign waddr  = ADDR_W'(pos_y) * ADDR_W'(MAX_SIDE) + ADDR_W'(pos_x);

    always_ff @(posedge clk)
    begin
        if (ctrl.accept)
        begin
            px_reg    <= pos_x;
            py_reg    <= pos_y;
            range_reg <= in_range;
        end
    end

    assign xt = $signed({1'b0, DIM_W'(px_reg)}) - $signed({1'b0, hw});
    assign yt = $signed({1'b0, DIM_W'(py_reg)}) - $signed({1'b0, hh});

    always_ff @(posedge clk)
    begin
        if (ctrl.mul_en)
        begin
            p_cx_reg <= $signed(cos_zoom_reg) * xt;
            p_sy_reg <= $signed(sin_zoom_reg) * yt;
            p_sx_reg <= $signed(sin_zoom_reg) * xt;
            p_cy_reg <= $signed(cos_zoom_reg) * yt;
        end
    end

    assign sum_x = SUM_W'(p_cx_reg) - SUM_W'(p_sy_reg);
    assign sum_y = SUM_W'(p_sx_reg) + SUM_W'(p_cy_reg);

    assign w_ext = $signed({{(COORD_W-DIM_W){1'b0}}, w_eff});
    assign h_ext = $signed({{(COORD_W-DIM_W){1'b0}}, h_eff});
    assign xs = COORD_W'($signed(sum_x[SUM_W-1:FRAC_BITS]))
                + $signed({{(COORD_W-DIM_W){1'b0}}, hw});
    assign ys = COORD_W'($signed(sum_y[SUM_W-1:FRAC_BITS]))
                + $signed({{(COORD_W-DIM_W){1'b0}}, hh});
    assign mapped_in = !xs[COORD_W-1] && (xs < w_ext) && !ys[COORD_W-1] && (ys < h_ext);

    always_ff @(posedge clk)
    begin
        if (ctrl.sum_en)
        begin
            xs_idx_reg <= xs[IDX_W-1:0];
            ys_idx_reg <= ys[IDX_W-1:0];
            hit_reg    <= range_reg && mapped_in;
        end
    end

    assign raddr = ADDR_W'(ys_idx_reg) * ADDR_W'(MAX_SIDE) + ADDR_W'(xs_idx_reg);

    rzs_ram #(
        .WIDTH (1),
        .DEPTH (DEPTH)
    ) u_bitmap (
        .clk   (clk),
        .we    (ram_we),
        .waddr (waddr),
        .wdata (pixel_in),
        .re    (ctrl.read_en),
        .raddr (raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk)
    begin
        if (ctrl.out_load)
        begin
            pixel_out_reg  <= hit_reg && ram_rdata;
            source_hit_reg <= hit_reg;
        end
    end

    assign pixel_out  = pixel_out_reg;
    assign source_hit = source_hit_reg;

endmodule

@@ hw/rtl/bitmap_rotate_zoom_sampler_unit.sv @@
// Top level of the bitmap rotate/zoom sampler: controller plus datapath.
// Uses rzs_pkg, rzs_ctrl, rzs_datapath (and rzs_ram through it).
//
//  channel  | signals                                   | dir
//  ---------+-------------------------------------------+-----
//  in       | in_valid in_ready cmd pos_x pos_y pixel_in | in
//  out      | out_valid out_ready pixel_out source_hit   | out
//  config   | cfg_we cfg_index cfg_data                  | in
//
// A write request updates the bitmap on accept, when in range, and leaves the
// controller idle; a query request shows its result after multiply, sum,
// RAM read and output load, set by the controller sequence and the
// registered RAM read port; the next request is taken after the output load.
// in_ready is high only while the controller is idle.
// A pending result stalls the controller in its last step until taken.
// Reset is asynchronous; the bitmap is not cleared.
module bitmap_rotate_zoom_sampler_unit import rzs_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  cmd,
    input  logic [POS_W-1:0]      pos_x,
    input  logic [POS_W-1:0]      pos_y,
    input  logic                  pixel_in,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  pixel_out,
    output logic                  source_hit
);

    ctrl_cmd_t    ctrl;
    ctrl_status_t status;

    rzs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (ctrl)
    );

    rzs_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .cmd        (cmd),
        .pos_x      (pos_x),
        .pos_y      (pos_y),
        .pixel_in   (pixel_in),
        .ctrl       (ctrl),
        .status     (status),
        .pixel_out  (pixel_out),
        .source_hit (source_hit)
    );

endmodule
